// ----- rtl/ccrfp_pkg.sv -----
// shared types, constants and the crc-16 byte update for the reply frame parser
// no dependencies
package ccrfp_pkg;

    localparam logic [7:0]  StartByte   = 8'h02;
    localparam logic [15:0] CrcPoly     = 16'h1021;
    // a length byte of zero stands for this many payload bytes
    localparam logic [8:0]  ZeroLenSize = 9'd256;
    localparam logic [8:0]  MaxPayload  = 9'd256;

    localparam logic [1:0] ErrNone   = 2'd0;
    localparam logic [1:0] ErrStatus = 2'd1;
    localparam logic [1:0] ErrHeader = 2'd2;
    localparam logic [1:0] ErrCrc    = 2'd3;

    typedef enum logic [3:0] {
        ST_HUNT = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_DATA = 4'b0100,
        ST_CRC  = 4'b1000
    } t_state;

    // classified beat as it waits in the queue
    typedef struct packed {
        logic       restart;
        logic       is_start;
        logic       is_zero;
        logic [7:0] data;
    } t_cmd;

    // queue head as seen by the parser
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // one result beat
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       frame_ok;
        logic [1:0] error_code;
    } t_result;

    // crc-16, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/ccrfp_if.sv -----
// valid/ready channel interfaces for the input beats and the result beats
// no dependencies
interface ccrfp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ccrfp_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_ok;
    logic [1:0] error_code;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_done, output frame_ok,
                    output error_code, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_index, input frame_done, input frame_ok,
                    input error_code, output ready);
endinterface

// ----- rtl/ccrfp_front.sv -----
// front end: takes input beats, classifies them and queues them for the parser
// depends on ccrfp_pkg and ccrfp_in_if
module ccrfp_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ccrfp_in_if.sink              i_in,
    input  logic                  i_pop,
    output ccrfp_pkg::t_qhead     o_head
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    ccrfp_pkg::t_cmd r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    ccrfp_pkg::t_cmd c_cmd;
    logic            c_push;

    // classify the incoming beat
    always_comb begin
        c_cmd.restart  = i_in.op;
        c_cmd.is_start = (i_in.rx_byte == ccrfp_pkg::StartByte);
        c_cmd.is_zero  = (i_in.rx_byte == 8'h00);
        c_cmd.data     = i_in.rx_byte;
    end

    assign i_in.ready = (r_count != FullCnt);
    assign c_push     = i_in.valid && i_in.ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr] <= c_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (c_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (c_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!c_push && i_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FullCnt && !i_pop) |=> (r_count == FullCnt))
        else $error("queue count moved while full and not popped");
`endif

endmodule

// ----- rtl/ccrfp_back.sv -----
// back end: frame state machine, crc check and the result output register
// depends on ccrfp_pkg and ccrfp_out_if
module ccrfp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccrfp_pkg::t_qhead     i_head,
    output logic                  o_pop,
    ccrfp_out_if.source           o_out
);

    ccrfp_pkg::t_state  r_state, n_state;
    logic [8:0]         r_cnt, n_cnt;
    logic [8:0]         r_len, n_len;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_first, n_first;
    logic [1:0]         r_herr, n_herr;
    ccrfp_pkg::t_result r_out, n_out;
    logic               r_out_valid;
    logic [15:0]        c_crc_upd;
    logic [8:0]         c_len;
    logic [8:0]         c_cnt_inc;
    logic [1:0]         c_code;
    ccrfp_pkg::t_cmd    c_cmd;

    // take the next beat whenever the output register is free or draining
    assign o_pop     = i_head.valid && (!r_out_valid || o_out.ready);
    assign c_cmd     = i_head.cmd;
    assign c_crc_upd = ccrfp_pkg::crc16_byte(r_crc, c_cmd.data);
    assign c_len     = c_cmd.is_zero ? ccrfp_pkg::ZeroLenSize : {1'b0, c_cmd.data};
    assign c_cnt_inc = r_cnt + 9'd1;

    // header error wins, then crc compare
    always_comb begin
        c_code = r_herr;
        if (r_herr == ccrfp_pkg::ErrNone &&
            (r_first != r_crc[15:8] || c_cmd.data != r_crc[7:0])) begin
            c_code = ccrfp_pkg::ErrCrc;
        end
    end

    // frame parsing
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_crc   = r_crc;
        n_first = r_first;
        n_herr  = r_herr;
        n_out   = '0;
        if (o_pop) begin
            if (c_cmd.restart) begin
                n_state = ccrfp_pkg::ST_HUNT;
                n_cnt   = '0;
                n_len   = '0;
                n_crc   = '0;
                n_first = '0;
                n_herr  = ccrfp_pkg::ErrNone;
            end else begin
                case (r_state)
                    ccrfp_pkg::ST_HUNT: begin
                        if (c_cmd.is_start) begin
                            n_state = ccrfp_pkg::ST_HEAD;
                            n_cnt   = '0;
                            n_len   = '0;
                            n_crc   = '0;
                            n_first = '0;
                            n_herr  = ccrfp_pkg::ErrNone;
                        end
                    end
                    ccrfp_pkg::ST_HEAD: begin
                        if (r_cnt == 9'd0) begin
                            if (!c_cmd.is_zero && r_herr == ccrfp_pkg::ErrNone) begin
                                n_herr = ccrfp_pkg::ErrStatus;
                            end
                            n_cnt = 9'd1;
                        end else if (r_cnt == 9'd1) begin
                            if (!c_cmd.is_zero && r_herr == ccrfp_pkg::ErrNone) begin
                                n_herr = ccrfp_pkg::ErrHeader;
                            end
                            n_crc = c_crc_upd;
                            n_cnt = 9'd2;
                        end else if (c_len > ccrfp_pkg::MaxPayload) begin
                            // oversized frame: drop it and hunt again
                            n_state = ccrfp_pkg::ST_HUNT;
                            n_cnt   = '0;
                            n_len   = '0;
                            n_crc   = '0;
                            n_first = '0;
                            n_herr  = ccrfp_pkg::ErrNone;
                        end else begin
                            n_crc   = c_crc_upd;
                            n_len   = c_len;
                            n_cnt   = '0;
                            n_state = ccrfp_pkg::ST_DATA;
                        end
                    end
                    ccrfp_pkg::ST_DATA: begin
                        n_out.payload_valid = 1'b1;
                        n_out.payload_byte  = c_cmd.data;
                        n_out.payload_index = r_cnt[7:0];
                        n_crc               = c_crc_upd;
                        if (c_cnt_inc >= r_len) begin
                            n_cnt   = '0;
                            n_state = ccrfp_pkg::ST_CRC;
                        end else begin
                            n_cnt = c_cnt_inc;
                        end
                    end
                    ccrfp_pkg::ST_CRC: begin
                        if (r_cnt == 9'd0) begin
                            n_first = c_cmd.data;
                            n_cnt   = 9'd1;
                        end else begin
                            n_out.frame_done = 1'b1;
                            n_out.frame_ok   = (c_code == ccrfp_pkg::ErrNone);
                            n_out.error_code = c_code;
                            n_state = ccrfp_pkg::ST_HUNT;
                            n_cnt   = '0;
                            n_len   = '0;
                            n_crc   = '0;
                            n_first = '0;
                            n_herr  = ccrfp_pkg::ErrNone;
                        end
                    end
                    default: begin
                        n_state = ccrfp_pkg::ST_HUNT;
                        n_cnt   = '0;
                        n_len   = '0;
                        n_crc   = '0;
                        n_first = '0;
                        n_herr  = ccrfp_pkg::ErrNone;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccrfp_pkg::ST_HUNT;
            r_cnt   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_first <= '0;
            r_herr  <= ccrfp_pkg::ErrNone;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_first <= n_first;
            r_herr  <= n_herr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_index = r_out.payload_index;
    assign o_out.frame_done    = r_out.frame_done;
    assign o_out.frame_ok      = r_out.frame_ok;
    assign o_out.error_code    = r_out.error_code;

`ifndef SYNTHESIS
    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |->
            (r_out.frame_ok == (r_out.error_code == ccrfp_pkg::ErrNone)))
        else $error("frame_ok disagrees with error_code");
    a_payload_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.payload_valid && r_out.frame_done))
        else $error("payload beat also marked frame done");
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccrfp_pkg::ST_DATA) |-> (r_cnt < r_len))
        else $error("payload count reached length while in data phase");
`endif

endmodule

// ----- rtl/crc_checked_reply_frame_parser_top.sv -----
// Reply frame parser with CRC-16 check.
// Channels: i_in carries one beat per received serial byte (op = 0) or a
// restart command (op = 1); o_out carries exactly one result beat for every
// input beat, in order: payload byte with its index, frame done with ok and
// error code, or an all-zero beat.
// Path: an accepted beat is written into the queue, parsed when the back end pops
// it from the queue head, and its result is held in the output register.
// Throughput: one beat per cycle while o_out.ready is high; the crc update of a
// whole byte and the frame state machine both resolve combinationally in the parser.
// Reset (i_rst_n low, synchronous): the queue empties, the parser hunts for a
// start byte and no result is pending.
// Stall: when o_out.ready is low the result holds in the output register,
// the queue of QUEUE_DEPTH beats fills, and then i_in.ready drops.
// depends on ccrfp_pkg, ccrfp_if, ccrfp_front, ccrfp_back
module crc_checked_reply_frame_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccrfp_in_if.sink    i_in,
    ccrfp_out_if.source o_out
);

    ccrfp_pkg::t_qhead w_head;
    logic              w_pop;

    // classify and queue
    ccrfp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // parse and report
    ccrfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
